@@ rtl/core/gaussian_blur_stream_filter_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Gaussian blur stream filter assertion macros
// Shared concurrent assertion forms used by the block's checker.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_BLUR_STREAM_FILTER_UNIT_DEFINES_SVH
`define GAUSSIAN_BLUR_STREAM_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define GBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define GBS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/gbs_pkg.sv @@
// ----------------------------------------------------------------------------
// Gaussian blur stream filter package
// Field widths, codes, defaults and pipeline structures shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gbs_pkg;

  localparam int ACT_W   = 2;
  localparam int PIX_W   = 8;
  localparam int CIDX_W  = 6;
  localparam int COEF_W  = 16;
  localparam int KH_W    = 2;
  localparam int IMW_W   = 11;
  localparam int HGT_W   = 13;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 13;

  localparam int DEF_MAX_KERNEL = 7;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT     = 4096;

  localparam logic [ACT_W-1:0] ACT_COEF  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PIXEL = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DRAIN = 2'd2;

  localparam logic [CFG_AW-1:0] CFG_KHALF  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [KH_W-1:0]  KH_RST = 2'd1;
  localparam logic [IMW_W-1:0] W_RST  = 11'd640;
  localparam logic [HGT_W-1:0] H_RST  = 13'd480;

  typedef struct packed {
    logic              vld;
    logic [CIDX_W-1:0] idx;
    logic [COEF_W-1:0] val;
  } gbs_cload_t;

  typedef struct packed {
    logic             emit;
    logic             shift;
    logic             border;
    logic             last;
    logic [PIX_W-1:0] pixel;
    gbs_cload_t       cload;
  } gbs_tag_t;

  typedef struct packed {
    logic             emit;
    logic             border;
    logic             last;
    logic [PIX_W-1:0] hval;
  } gbs_res_t;

endpackage

@@ rtl/core/gbs_if.sv @@
// ----------------------------------------------------------------------------
// Gaussian blur stream filter channels
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gbs_in_if import gbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [PIX_W-1:0]  pixel_in;
  logic [CIDX_W-1:0] coef_index;
  logic [COEF_W-1:0] coef_value;

  modport source (output valid, action, pixel_in, coef_index, coef_value, input ready);
  modport sink (input valid, action, pixel_in, coef_index, coef_value, output ready);
endinterface

interface gbs_out_if import gbs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             is_border;
  logic             frame_last;

  modport source (output valid, pixel_out, is_border, frame_last, input ready);
  modport sink (input valid, pixel_out, is_border, frame_last, output ready);
endinterface

interface gbs_cfg_if import gbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] index;
  logic [CFG_DW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/gaussian_blur_stream_filter_unit.sv @@
// ----------------------------------------------------------------------------
// Gaussian blur stream filter unit
// Takes one word per clock: a coefficient load, a raster-order pixel or a
// drain step, and returns at most one filtered or border pixel per word.
// A result passes through the tag register and the res2, res3 and res4 stages
// into the output register. The unit keeps taking words while a result waits,
// stalling only when an untaken result sits in the output register and the last
// pipeline stage holds one too. The one-word-per-clock rate comes from the line
// buffers, RAMs with one read and one write per clock, and the parallel products.
// The RAMs have no reset and need no clearing pass; coefficients reset to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gaussian_blur_stream_filter_unit import gbs_pkg::*; #(
  parameter int MAX_KERNEL = DEF_MAX_KERNEL,
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  gbs_in_if.sink     in_chan,
  gbs_out_if.source  out_chan,
  gbs_cfg_if.sink    cfg_chan
);

  localparam int HALF_MAX = (MAX_KERNEL - 1) / 2;
  localparam int LBAW     = $clog2(MAX_WIDTH);
  localparam int HIST_AW  = $clog2(HALF_MAX * MAX_WIDTH + HALF_MAX + 2);
  localparam int TSW      = PIX_W + COEF_W + 2 * $clog2(MAX_KERNEL);

  logic                  en;
  logic [KH_W-1:0]       kh_eff;
  logic [LBAW-1:0]       rd_col, wr_col_r;
  gbs_tag_t              tag_r;
  logic                  hist_we;
  logic [HIST_AW-1:0]    hist_waddr, hist_raddr;
  logic [PIX_W-1:0]      hist_rd;
  gbs_res_t              res2_r, res3_r, res4_r;
  gbs_cload_t            cl2_r;
  logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][PIX_W-1:0] win;
  logic [TSW-1:0]        sum;
  logic [PIX_W-1:0]      filt;

  logic                  out_valid_r;
  logic [PIX_W-1:0]      out_pixel_r;
  logic                  out_border_r, out_last_r;

  assign en             = !(out_valid_r && !out_chan.ready && res4_r.emit);
  assign in_chan.ready  = en;
  assign cfg_chan.ready = 1'b1;

  gbs_ctrl #(
    .MAX_KERNEL (MAX_KERNEL),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_chan.valid),
    .in_action  (in_chan.action),
    .in_pixel   (in_chan.pixel_in),
    .in_cidx    (in_chan.coef_index),
    .in_cval    (in_chan.coef_value),
    .cfg_we     (cfg_chan.valid),
    .cfg_idx    (cfg_chan.index),
    .cfg_data   (cfg_chan.data),
    .kh_eff     (kh_eff),
    .rd_col     (rd_col),
    .wr_col_r   (wr_col_r),
    .tag_r      (tag_r),
    .hist_we    (hist_we),
    .hist_waddr (hist_waddr),
    .hist_raddr (hist_raddr)
  );

  gbs_ram #(
    .DW (PIX_W),
    .AW (HIST_AW)
  ) u_hist (
    .clk     (clk),
    .re      (en),
    .we      (hist_we),
    .waddr   (hist_waddr),
    .wdata   (in_chan.pixel_in),
    .raddr   (hist_raddr),
    .rdata_r (hist_rd)
  );

  gbs_window #(
    .MAX_KERNEL (MAX_KERNEL),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_window (
    .clk    (clk),
    .en     (en),
    .shift  (en && tag_r.shift),
    .rd_col (rd_col),
    .wr_col (wr_col_r),
    .pixel  (tag_r.pixel),
    .win_r  (win)
  );

  gbs_mac #(
    .MAX_KERNEL (MAX_KERNEL)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .cload  (cl2_r),
    .kh_eff (kh_eff),
    .win    (win),
    .sum    (sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res2_r <= '0;
      res3_r <= '0;
      res4_r <= '0;
      cl2_r  <= '0;
    end else if (en) begin
      res2_r.emit   <= tag_r.emit;
      res2_r.border <= tag_r.border;
      res2_r.last   <= tag_r.last;
      res2_r.hval   <= hist_rd;
      res3_r        <= res2_r;
      res4_r        <= res3_r;
      cl2_r         <= tag_r.cload;
    end
  end

  assign filt = (|sum[TSW-1:COEF_W+PIX_W]) ? '1 : sum[COEF_W+PIX_W-1:COEF_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_chan.ready) begin
      out_valid_r <= res4_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_chan.ready) begin
      out_pixel_r  <= res4_r.border ? res4_r.hval : filt;
      out_border_r <= res4_r.border;
      out_last_r   <= res4_r.last;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.pixel_out  = out_pixel_r;
  assign out_chan.is_border  = out_border_r;
  assign out_chan.frame_last = out_last_r;

endmodule

@@ rtl/core/gbs_ram.sv @@
// ----------------------------------------------------------------------------
// Gaussian blur stream filter RAM
// One write port and one registered read port with write-first bypass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gbs_ram #(
  parameter int DW = 8,
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          re,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata_r
);

  logic [DW-1:0] mem_r [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= (we && (waddr == raddr)) ? wdata : mem_r[raddr];
    end
  end

endmodule

@@ rtl/core/gbs_ctrl.sv @@
// ----------------------------------------------------------------------------
// Gaussian blur stream filter control
// Register file, frame positions, emission decision and border test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gbs_ctrl import gbs_pkg::*; #(
  parameter int MAX_KERNEL = DEF_MAX_KERNEL,
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [ACT_W-1:0]   in_action,
  input  logic [PIX_W-1:0]   in_pixel,
  input  logic [CIDX_W-1:0]  in_cidx,
  input  logic [COEF_W-1:0]  in_cval,
  input  logic               cfg_we,
  input  logic [CFG_AW-1:0]  cfg_idx,
  input  logic [CFG_DW-1:0]  cfg_data,
  output logic [KH_W-1:0]    kh_eff,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_col,
  output logic [$clog2(MAX_WIDTH)-1:0] wr_col_r,
  output gbs_tag_t           tag_r,
  output logic               hist_we,
  output logic [$clog2(((MAX_KERNEL-1)/2)*MAX_WIDTH+(MAX_KERNEL-1)/2+2)-1:0] hist_waddr,
  output logic [$clog2(((MAX_KERNEL-1)/2)*MAX_WIDTH+(MAX_KERNEL-1)/2+2)-1:0] hist_raddr
);

  localparam int HALF_MAX = (MAX_KERNEL - 1) / 2;
  localparam int WCW      = $clog2(MAX_WIDTH + 1);
  localparam int LBAW     = $clog2(MAX_WIDTH);
  localparam int PW       = WCW + HGT_W;
  localparam int HIST_AW  = $clog2(HALF_MAX * MAX_WIDTH + HALF_MAX + 2);
  localparam int CDEPTH   = MAX_KERNEL * MAX_KERNEL;

  logic [KH_W-1:0]  cfg_kh_r, cfg_kh_nxt;
  logic [IMW_W-1:0] cfg_w_r, cfg_w_nxt;
  logic [HGT_W-1:0] cfg_h_r, cfg_h_nxt;
  logic [PW-1:0]    in_pos_r, in_pos_nxt, out_pos_r, out_pos_nxt;
  logic [WCW-1:0]   in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [HGT_W-1:0] out_row_r, out_row_nxt;

  logic [WCW-1:0]   w_eff;
  logic [HGT_W-1:0] h_eff;
  logic [PW-1:0]    total, hwh, in_new;
  logic [PW:0]      reach;
  logic             accept, is_coef, pix_wr, emit, last, border;
  gbs_tag_t         tag_nxt;

  always_comb begin
    if (cfg_kh_r == '0) begin
      kh_eff = KH_W'(1);
    end else if (32'(cfg_kh_r) > HALF_MAX) begin
      kh_eff = KH_W'(HALF_MAX);
    end else begin
      kh_eff = cfg_kh_r;
    end
    if (cfg_w_r == '0) begin
      w_eff = WCW'(1);
    end else if (32'(cfg_w_r) > MAX_WIDTH) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = WCW'(cfg_w_r);
    end
    if (cfg_h_r == '0) begin
      h_eff = HGT_W'(1);
    end else if (32'(cfg_h_r) > MAX_HEIGHT) begin
      h_eff = HGT_W'(MAX_HEIGHT);
    end else begin
      h_eff = cfg_h_r;
    end
  end

  assign total   = PW'(w_eff) * PW'(h_eff);
  assign hwh     = PW'(kh_eff) * PW'(w_eff) + PW'(kh_eff);
  assign accept  = in_valid && en;
  assign is_coef = (in_action == ACT_COEF);
  assign pix_wr  = accept && (in_action == ACT_PIXEL) && (in_pos_r < total);
  assign in_new  = in_pos_r + PW'(pix_wr);
  assign reach   = {1'b0, out_pos_r} + {1'b0, hwh};
  assign emit    = accept && !is_coef && ((reach < {1'b0, in_new}) || (in_new == total));
  assign last    = (out_pos_r == total - PW'(1));
  assign border  = (out_row_r < HGT_W'(kh_eff))
                || (({1'b0, out_row_r} + (HGT_W+1)'(kh_eff)) >= {1'b0, h_eff})
                || (out_col_r < WCW'(kh_eff))
                || (({1'b0, out_col_r} + (WCW+1)'(kh_eff)) >= {1'b0, w_eff});

  always_comb begin
    cfg_kh_nxt  = cfg_kh_r;
    cfg_w_nxt   = cfg_w_r;
    cfg_h_nxt   = cfg_h_r;
    in_pos_nxt  = in_pos_r;
    in_col_nxt  = in_col_r;
    out_pos_nxt = out_pos_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (pix_wr) begin
      in_pos_nxt = in_new;
      in_col_nxt = (in_col_r == w_eff - WCW'(1)) ? '0 : in_col_r + WCW'(1);
    end
    if (emit) begin
      if (last) begin
        in_pos_nxt  = '0;
        in_col_nxt  = '0;
        out_pos_nxt = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end else begin
        out_pos_nxt = out_pos_r + PW'(1);
        if (out_col_r == w_eff - WCW'(1)) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + HGT_W'(1);
        end else begin
          out_col_nxt = out_col_r + WCW'(1);
        end
      end
    end
    if (cfg_we && (cfg_idx inside {CFG_KHALF, CFG_WIDTH, CFG_HEIGHT})) begin
      case (cfg_idx)
        CFG_KHALF:  cfg_kh_nxt = cfg_data[KH_W-1:0];
        CFG_WIDTH:  cfg_w_nxt  = cfg_data[IMW_W-1:0];
        CFG_HEIGHT: cfg_h_nxt  = cfg_data[HGT_W-1:0];
        default:    cfg_kh_nxt = cfg_kh_r;
      endcase
      in_pos_nxt  = '0;
      in_col_nxt  = '0;
      out_pos_nxt = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end
  end

  always_comb begin
    tag_nxt.emit      = emit;
    tag_nxt.shift     = pix_wr;
    tag_nxt.border    = border;
    tag_nxt.last      = last;
    tag_nxt.pixel     = in_pixel;
    tag_nxt.cload.vld = accept && is_coef && (32'(in_cidx) < CDEPTH);
    tag_nxt.cload.idx = in_cidx;
    tag_nxt.cload.val = in_cval;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_kh_r  <= KH_RST;
      cfg_w_r   <= W_RST;
      cfg_h_r   <= H_RST;
      in_pos_r  <= '0;
      in_col_r  <= '0;
      out_pos_r <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      tag_r     <= '0;
    end else begin
      cfg_kh_r  <= cfg_kh_nxt;
      cfg_w_r   <= cfg_w_nxt;
      cfg_h_r   <= cfg_h_nxt;
      in_pos_r  <= in_pos_nxt;
      in_col_r  <= in_col_nxt;
      out_pos_r <= out_pos_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      if (en) begin
        tag_r <= tag_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wr_col_r <= in_col_r[LBAW-1:0];
    end
  end

  assign rd_col     = in_col_r[LBAW-1:0];
  assign hist_we    = pix_wr;
  assign hist_waddr = in_pos_r[HIST_AW-1:0];
  assign hist_raddr = out_pos_r[HIST_AW-1:0];

endmodule

@@ rtl/core/gbs_window.sv @@
// ----------------------------------------------------------------------------
// Gaussian blur stream filter window
// Cascaded line buffers feeding a square shift-register window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gbs_window import gbs_pkg::*; #(
  parameter int MAX_KERNEL = DEF_MAX_KERNEL,
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         shift,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_col,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_col,
  input  logic [PIX_W-1:0]             pixel,
  output logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][PIX_W-1:0] win_r
);

  localparam int LBAW = $clog2(MAX_WIDTH);

  logic [MAX_KERNEL-2:0][PIX_W-1:0] lb_rd;
  logic [MAX_KERNEL-2:0][PIX_W-1:0] lb_wd;
  logic [MAX_KERNEL-1:0][PIX_W-1:0] col_in;

  always_comb begin
    lb_wd[0]  = pixel;
    col_in[0] = pixel;
    for (int k = 1; k < MAX_KERNEL - 1; k++) begin
      lb_wd[k] = lb_rd[k-1];
    end
    for (int a = 1; a < MAX_KERNEL; a++) begin
      col_in[a] = lb_rd[a-1];
    end
  end

  for (genvar k = 0; k < MAX_KERNEL - 1; k++) begin : g_line
    gbs_ram #(
      .DW (PIX_W),
      .AW (LBAW)
    ) u_line (
      .clk     (clk),
      .re      (en),
      .we      (shift),
      .waddr   (wr_col),
      .wdata   (lb_wd[k]),
      .raddr   (rd_col),
      .rdata_r (lb_rd[k])
    );
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      for (int a = 0; a < MAX_KERNEL; a++) begin
        win_r[a] <= {win_r[a][MAX_KERNEL-2:0], col_in[a]};
      end
    end
  end

endmodule

@@ rtl/core/gbs_mac.sv @@
// ----------------------------------------------------------------------------
// Gaussian blur stream filter multiply-accumulate
// Coefficient table, parallel window products and a registered adder tree.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gbs_mac import gbs_pkg::*; #(
  parameter int MAX_KERNEL = DEF_MAX_KERNEL
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  gbs_cload_t       cload,
  input  logic [KH_W-1:0]  kh_eff,
  input  logic [MAX_KERNEL-1:0][MAX_KERNEL-1:0][PIX_W-1:0] win,
  output logic [PIX_W+COEF_W+2*$clog2(MAX_KERNEL)-1:0] sum
);

  localparam int HALF_MAX = (MAX_KERNEL - 1) / 2;
  localparam int CDEPTH   = MAX_KERNEL * MAX_KERNEL;
  localparam int CAW      = $clog2(CDEPTH);
  localparam int PRW      = PIX_W + COEF_W;
  localparam int RSW      = PRW + $clog2(MAX_KERNEL);
  localparam int TSW      = RSW + $clog2(MAX_KERNEL);

  logic [COEF_W-1:0] coef_r [CDEPTH];
  logic [PRW-1:0]    prod_r [MAX_KERNEL][MAX_KERNEL];
  logic [PRW-1:0]    prod_nxt [MAX_KERNEL][MAX_KERNEL];
  logic [RSW-1:0]    rsum_r [MAX_KERNEL];
  logic [RSW-1:0]    rsum_nxt [MAX_KERNEL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CDEPTH; i++) begin
        coef_r[i] <= '0;
      end
    end else if (en && cload.vld) begin
      coef_r[cload.idx[CAW-1:0]] <= cload.val;
    end
  end

  always_comb begin
    logic [PIX_W-1:0] sel;
    for (int ki = 0; ki < MAX_KERNEL; ki++) begin
      for (int kj = 0; kj < MAX_KERNEL; kj++) begin
        sel = '0;
        for (int hh = 1; hh <= HALF_MAX; hh++) begin
          if ((kh_eff == KH_W'(hh)) && (ki <= 2 * hh) && (kj <= 2 * hh)) begin
            sel = win[(ki <= 2 * hh) ? 2 * hh - ki : 0][(kj <= 2 * hh) ? 2 * hh - kj : 0];
          end
        end
        prod_nxt[ki][kj] = PRW'(sel) * PRW'(coef_r[ki * MAX_KERNEL + kj]);
      end
    end
  end

  always_comb begin
    logic [RSW-1:0] acc;
    for (int ki = 0; ki < MAX_KERNEL; ki++) begin
      acc = '0;
      for (int kj = 0; kj < MAX_KERNEL; kj++) begin
        acc = acc + RSW'(prod_r[ki][kj]);
      end
      rsum_nxt[ki] = acc;
    end
  end

  always_comb begin
    logic [TSW-1:0] tot;
    tot = '0;
    for (int ki = 0; ki < MAX_KERNEL; ki++) begin
      tot = tot + TSW'(rsum_r[ki]);
    end
    sum = tot;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      rsum_r <= rsum_nxt;
    end
  end

endmodule

@@ rtl/core/gbs_checker.sv @@
// ----------------------------------------------------------------------------
// Gaussian blur stream filter checker
// Port-level assertions on the block, attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gaussian_blur_stream_filter_unit_defines.svh"

module gbs_checker import gbs_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] out_pixel,
  input logic             out_is_border,
  input logic             out_frame_last
);

  `GBS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped while stalled")
  `GBS_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_pixel) && $stable(out_is_border) && $stable(out_frame_last), "result word changed while stalled")
  `GBS_ASSERT_NOW(a_stall_cause, !in_ready, out_valid && !out_ready, "input stalled without a waiting result")
  `GBS_ASSERT_NOW(a_last_border, out_valid && out_frame_last, out_is_border, "last pixel of frame not from border band")

endmodule

bind gaussian_blur_stream_filter_unit gbs_checker u_gbs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_pixel      (out_chan.pixel_out),
  .out_is_border  (out_chan.is_border),
  .out_frame_last (out_chan.frame_last)
);

@@ tb/tb_gaussian_blur_stream_filter_unit.sv @@
// ----------------------------------------------------------------------------
// Gaussian blur stream filter testbench
// Streams small frames through the filter under random kernels, frame sizes,
// sender bursts and receiver stalls. A cycle-free model of the line buffers
// and window sums predicts every result word, which is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gaussian_blur_stream_filter_unit;
  import gbs_pkg::*;

  localparam int KMAX = DEF_MAX_KERNEL;
  localparam int COEF_SLOTS = KMAX * KMAX;
  localparam int HIST_LEN = (KMAX - 1) * DEF_MAX_WIDTH + KMAX;
  localparam int SETTLE = 12;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ROWS = 20;
  localparam logic [CFG_AW-1:0] CFG_SPARE = 2'd3;
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             border;
    logic             last;
  } blur_px_t;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [PIX_W-1:0]  pix;
    logic [CIDX_W-1:0] idx;
    logic [COEF_W-1:0] val;
    logic              typed;
    blur_px_t          want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  gbs_in_if  in_if();
  gbs_out_if out_if();
  gbs_cfg_if cfg_if();

  gaussian_blur_stream_filter_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Model state of the filter.
  logic [PIX_W-1:0]  line_hist [HIST_LEN];
  logic [COEF_W-1:0] coefs [COEF_SLOTS];
  int unsigned       in_pos;
  int unsigned       out_pos;
  logic [KH_W-1:0]   khalf_reg;
  logic [IMW_W-1:0]  width_reg;
  logic [HGT_W-1:0]  height_reg;

  blur_px_t blurred_q[$];
  int       fails = 0;
  int       cycles = 0;
  int       words_sent = 0;
  logic     in_took = 1'b0;
  logic     cfg_took = 1'b0;
  logic     cur_typed = 1'b0;
  blur_px_t cur_want = '0;
  bit       tx_gaps = 1'b0;
  int       burst_left = 0;
  int       rx_mode = 0;
  bit       hold_req = 1'b0;
  int       hold_left = 0;
  int       run_left = 0;
  bit       run_on = 1'b1;

  function automatic int unsigned eff_half();
    int unsigned h;
    h = 32'(khalf_reg);
    if (h < 1) h = 1;
    if (h > (KMAX - 1) / 2) h = (KMAX - 1) / 2;
    return h;
  endfunction

  function automatic int unsigned frame_pixels();
    int unsigned w;
    int unsigned ht;
    w = 32'(width_reg);
    ht = 32'(height_reg);
    if (w < 1) w = 1;
    if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
    if (ht < 1) ht = 1;
    if (ht > MAX_HEIGHT) ht = MAX_HEIGHT;
    return w * ht;
  endfunction

  function automatic bit blur_step(input logic [ACT_W-1:0] act, input logic [PIX_W-1:0] pix,
                                   input logic [CIDX_W-1:0] idx,
                                   input logic [COEF_W-1:0] val, output blur_px_t px);
    int unsigned h, w, ht, total, need, p, r, c, sum, src, value, ki, kj;
    bit border;
    px = '0;
    h = eff_half();
    total = frame_pixels();
    w = 32'(width_reg);
    if (w < 1) w = 1;
    if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
    ht = total / w;
    if (act == ACT_COEF) begin
      if (idx < COEF_SLOTS) coefs[idx] = val;
      return 1'b0;
    end
    if (act == ACT_PIXEL && in_pos < total) begin
      line_hist[in_pos % HIST_LEN] = pix;
      in_pos++;
    end
    if (out_pos >= total) return 1'b0;
    p = out_pos;
    need = p + h * w + h;
    if (need > total - 1) need = total - 1;
    if (need >= in_pos) return 1'b0;
    r = p / w;
    c = p % w;
    border = (r < h) || (r + h >= ht) || (c < h) || (c + h >= w);
    if (border) begin
      value = 32'(line_hist[p % HIST_LEN]);
    end else begin
      sum = 0;
      for (ki = 0; ki < 2 * h + 1; ki++) begin
        for (kj = 0; kj < 2 * h + 1; kj++) begin
          src = (r + ki - h) * w + (c + kj - h);
          sum += int'(line_hist[src % HIST_LEN]) * int'(coefs[ki * KMAX + kj]);
        end
      end
      value = sum >> 16;
      if (value > 255) value = 255;
    end
    px.pix = value[PIX_W-1:0];
    px.border = border;
    px.last = (p == total - 1);
    if (px.last) begin
      in_pos = 0;
      out_pos = 0;
    end else begin
      out_pos = p + 1;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin : monitor
    blur_px_t px;
    blur_px_t want;
    bit got;
    in_took <= rst_n && in_if.valid && in_if.ready;
    cfg_took <= rst_n && cfg_if.valid && cfg_if.ready;
    if (!rst_n) begin
      in_pos = 0;
      out_pos = 0;
      khalf_reg = KH_RST;
      width_reg = W_RST;
      height_reg = H_RST;
      for (int i = 0; i < COEF_SLOTS; i++) coefs[i] = '0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CFG_KHALF: khalf_reg = cfg_if.data[KH_W-1:0];
          CFG_WIDTH: width_reg = cfg_if.data[IMW_W-1:0];
          CFG_HEIGHT: height_reg = cfg_if.data[HGT_W-1:0];
          default: ;
        endcase
        if (cfg_if.index != CFG_SPARE) begin
          in_pos = 0;
          out_pos = 0;
        end
      end
      if (in_if.valid && in_if.ready) begin
        got = blur_step(in_if.action, in_if.pixel_in, in_if.coef_index, in_if.coef_value, px);
        if (got) blurred_q.push_back(cur_typed ? cur_want : px);
        else if (cur_typed) begin
          $display("%0t: word expected after this input, none predicted", $time);
          fails++;
        end
      end
      if (out_if.valid && out_if.ready) begin
        if (blurred_q.size() == 0) begin
          $display("%0t: unexpected result word pixel_out %0d", $time, out_if.pixel_out);
          fails++;
        end else begin
          want = blurred_q.pop_front();
          if (out_if.pixel_out !== want.pix) begin
            $display("%0t: pixel_out expected %0d actual %0d", $time, want.pix,
                     out_if.pixel_out);
            fails++;
          end
          if (out_if.is_border !== want.border) begin
            $display("%0t: is_border expected %0d actual %0d", $time, want.border,
                     out_if.is_border);
            fails++;
          end
          if (out_if.frame_last !== want.last) begin
            $display("%0t: frame_last expected %0d actual %0d", $time, want.last,
                     out_if.frame_last);
            fails++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if (run_left == 0) begin
            run_on = !run_on;
            run_left = run_on ? $urandom_range(1, 8) : $urandom_range(1, 5);
          end
          run_left--;
          out_if.ready <= run_on;
        end
      endcase
    end
  end

  task automatic put_word(input logic [ACT_W-1:0] act, input logic [PIX_W-1:0] pix,
                          input logic [CIDX_W-1:0] idx, input logic [COEF_W-1:0] val,
                          input logic typed = 1'b0, input blur_px_t want = '0);
    if (tx_gaps) begin
      if (burst_left == 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    in_if.valid <= 1'b1;
    in_if.action <= act;
    in_if.pixel_in <= pix;
    in_if.coef_index <= idx;
    in_if.coef_value <= val;
    cur_typed <= typed;
    cur_want <= want;
    words_sent++;
    do @(negedge clk); while (!in_took);
  endtask

  task automatic wait_quiet();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (blurred_q.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] index, input logic [CFG_DW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data <= data;
    do @(negedge clk); while (!cfg_took);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic load_kernel(input int unsigned top);
    for (int i = 0; i < COEF_SLOTS; i++) begin
      put_word(ACT_COEF, PIX_W'($urandom), CIDX_W'(i), COEF_W'($urandom_range(0, top)));
    end
  endtask

  task automatic stream_pixels(input int unsigned n, input bit noise);
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 19);
      if (noise && pick == 0) begin
        put_word(ACT_COEF, PIX_W'($urandom), CIDX_W'($urandom_range(0, 63)),
                 COEF_W'($urandom));
      end else if (noise && pick == 1) begin
        put_word($urandom_range(0, 1) ? ACT_DRAIN : ACT_SPARE, PIX_W'($urandom),
                 CIDX_W'($urandom), COEF_W'($urandom));
      end else begin
        put_word(ACT_PIXEL, PIX_W'($urandom), CIDX_W'($urandom), COEF_W'($urandom));
        sent++;
      end
    end
  endtask

  task automatic drain_frame();
    logic [ACT_W-1:0] act;
    while (in_pos != 0 || out_pos != 0) begin
      case ($urandom_range(0, 2))
        0: act = ACT_DRAIN;
        1: act = ACT_SPARE;
        default: act = ACT_PIXEL;
      endcase
      put_word(act, PIX_W'($urandom), CIDX_W'($urandom), COEF_W'($urandom));
    end
  endtask

  task automatic run_frame(input logic [CFG_DW-1:0] kh, input logic [CFG_DW-1:0] w,
                           input logic [CFG_DW-1:0] ht, input int unsigned coef_top,
                           input bit noise);
    wait_quiet();
    cfg_write(CFG_KHALF, kh);
    cfg_write(CFG_WIDTH, w);
    cfg_write(CFG_HEIGHT, ht);
    tx_gaps = 1'($urandom_range(0, 1));
    rx_mode = $urandom_range(0, 2);
    load_kernel(coef_top);
    stream_pixels(frame_pixels(), noise);
    drain_frame();
  endtask

  stim_row_t rows [ROWS] = '{
    '{ACT_DRAIN, 8'd0, 6'd0, 16'd0, 1'b0, '0},
    '{ACT_SPARE, 8'd0, 6'd0, 16'd0, 1'b0, '0},
    '{ACT_COEF, 8'd0, 6'd0, 16'hFFFF, 1'b0, '0},
    '{ACT_COEF, 8'd0, 6'd48, 16'hFFFF, 1'b0, '0},
    '{ACT_COEF, 8'd0, 6'd63, 16'h1234, 1'b0, '0},
    '{ACT_COEF, 8'd0, 6'd8, 16'h8000, 1'b0, '0},
    '{ACT_PIXEL, 8'd255, 6'd0, 16'd0, 1'b0, '0},
    '{ACT_PIXEL, 8'd0, 6'd0, 16'd0, 1'b0, '0},
    '{ACT_PIXEL, 8'd170, 6'd0, 16'd0, 1'b0, '0},
    '{ACT_PIXEL, 8'd85, 6'd0, 16'd0, 1'b0, '0},
    '{ACT_PIXEL, 8'd1, 6'd0, 16'd0, 1'b0, '0},
    '{ACT_PIXEL, 8'd128, 6'd0, 16'd0, 1'b0, '0},
    '{ACT_PIXEL, 8'd254, 6'd0, 16'd0, 1'b0, '0},
    '{ACT_PIXEL, 8'd255, 6'd0, 16'd0, 1'b0, '0},
    '{ACT_PIXEL, 8'd255, 6'd0, 16'd0, 1'b1, '{8'd255, 1'b1, 1'b0}},
    '{ACT_PIXEL, 8'd255, 6'd0, 16'd0, 1'b1, '{8'd0, 1'b1, 1'b0}},
    '{ACT_DRAIN, 8'd0, 6'd0, 16'd0, 1'b0, '0},
    '{ACT_PIXEL, 8'd0, 6'd0, 16'd0, 1'b1, '{8'd170, 1'b1, 1'b0}},
    '{ACT_COEF, 8'd0, 6'd9, 16'h4000, 1'b0, '0},
    '{ACT_PIXEL, 8'd7, 6'd0, 16'd0, 1'b1, '{8'd85, 1'b1, 1'b0}}
  };

  initial begin
    int unsigned small_words;
    in_if.valid = 1'b0;
    in_if.action = ACT_DRAIN;
    in_if.pixel_in = '0;
    in_if.coef_index = '0;
    in_if.coef_value = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_KHALF;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    cfg_write(CFG_KHALF, 13'd1);
    cfg_write(CFG_WIDTH, 13'd7);
    cfg_write(CFG_HEIGHT, 13'd7);
    for (int i = 0; i < ROWS; i++) begin
      put_word(rows[i].act, rows[i].pix, rows[i].idx, rows[i].val, rows[i].typed,
               rows[i].want);
    end
    stream_pixels(49 - 13, 1'b0);
    drain_frame();

    // Long receiver hold-off while pixels keep coming, then a full pause.
    wait_quiet();
    cfg_write(CFG_KHALF, 13'd2);
    cfg_write(CFG_WIDTH, 13'd9);
    cfg_write(CFG_HEIGHT, 13'd8);
    tx_gaps = 1'b0;
    rx_mode = 2;
    load_kernel(65535 / 25);
    hold_req = 1'b1;
    stream_pixels(40, 1'b0);
    wait_quiet();
    stream_pixels(32, 1'b1);
    drain_frame();

    // Restart in mid-frame by a register write.
    wait_quiet();
    cfg_write(CFG_HEIGHT, 13'd9);
    rx_mode = 1;
    stream_pixels(30, 1'b1);
    wait_quiet();
    cfg_write(CFG_SPARE, CFG_DW'($urandom));
    cfg_write(CFG_KHALF, 13'd0);
    stream_pixels(frame_pixels(), 1'b1);
    drain_frame();

    small_words = words_sent;
    while (words_sent - small_words < 150) begin
      case ($urandom_range(0, 5))
        0: run_frame(CFG_DW'($urandom_range(0, 3)), CFG_DW'($urandom_range(0, 6)),
                     CFG_DW'($urandom_range(0, 6)), 65535, 1'b1);
        1: run_frame(CFG_DW'($urandom_range(0, 3)), CFG_DW'($urandom_range(7, 12)),
                     CFG_DW'($urandom_range(7, 10)), 65535, 1'b1);
        default: run_frame(CFG_DW'($urandom_range(0, 3)), CFG_DW'($urandom_range(7, 12)),
                           CFG_DW'($urandom_range(7, 10)), 65535 / 9, 1'b1);
      endcase
    end

    wait_quiet();
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
